// ----- rtl/core/sha256c_pkg.sv -----
// shared types, constants and round functions for the sha-256 compression block
package sha256c_pkg;

  localparam int WordW    = 32;
  localparam int Rounds   = 64;
  localparam int BlkWords = 16;
  localparam int HashWords = 8;

  localparam logic [WordW-1:0] INIT_HASH [HashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } sha256c_state_t;

  typedef struct packed {
    logic       shift_in;   // push message word into the schedule window
    logic       start;      // load working vars from the chaining value
    logic       init_hash;  // restart from the initial hash value
    logic       round;      // run one compression round
    logic       update;     // add working vars into the chaining value
    logic       emit;       // load one digest word into the output register
    logic [5:0] round_idx;
    logic [2:0] emit_idx;
  } sha256c_cmd_t;

  typedef struct packed {
    logic out_free;
  } sha256c_stat_t;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] big_sig0(input logic [WordW-1:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordW-1:0] big_sig1(input logic [WordW-1:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WordW-1:0] small_sig0(input logic [WordW-1:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] small_sig1(input logic [WordW-1:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- rtl/core/sha256c_ctrl.sv -----
// controller state machine: word counting, round sequencing and digest output
module sha256c_ctrl
  import sha256c_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_first,
  input  logic          in_final,
  input  sha256c_stat_t stat,
  output sha256c_cmd_t  cmd
);

  sha256c_state_t state, state_next;
  logic [3:0] word_cnt;
  logic [5:0] round_cnt;
  logic [2:0] emit_cnt;
  logic       final_blk;
  logic       in_xfer;

  assign in_ready = (state == ST_LOAD);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_xfer && word_cnt == 4'(BlkWords - 1)) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (round_cnt == 6'(Rounds - 1)) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = final_blk ? ST_EMIT : ST_LOAD;
      end
      ST_EMIT: begin
        if (stat.out_free && emit_cnt == 3'(HashWords - 1)) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.round_idx = round_cnt;
    cmd.emit_idx  = emit_cnt;
    case (state)
      ST_LOAD: begin
        cmd.shift_in = in_xfer;
        if (in_xfer && word_cnt == 4'(BlkWords - 1)) begin
          cmd.start     = 1'b1;
          cmd.init_hash = in_first;
        end
      end
      ST_ROUND:  cmd.round  = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_EMIT:   cmd.emit   = stat.out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      word_cnt  <= '0;
      round_cnt <= '0;
      emit_cnt  <= '0;
      final_blk <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.shift_in) word_cnt <= word_cnt + 4'd1;
      if (cmd.start) begin
        final_blk <= in_final;
        round_cnt <= '0;
      end else if (cmd.round) begin
        round_cnt <= round_cnt + 6'd1;
      end
      if (cmd.update) emit_cnt <= '0;
      else if (cmd.emit) emit_cnt <= emit_cnt + 3'd1;
    end
  end

endmodule

// ----- rtl/core/sha256c_dp.sv -----
// datapath: schedule window, working variables, chaining value and output register
module sha256c_dp
  import sha256c_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  sha256c_cmd_t       cmd,
  output sha256c_stat_t      stat,
  input  logic [WordW-1:0]   in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WordW-1:0]   out_word,
  output logic [2:0]         out_idx,
  output logic               out_last
);

  logic [WordW-1:0] win [BlkWords];
  logic [WordW-1:0] v [HashWords];
  logic [WordW-1:0] h [HashWords];
  logic [WordW-1:0] w_new, t1, t2, ch, maj;

  assign stat.out_free = !out_valid || out_ready;

  // next schedule word from the rolling window, win[0] is the current round's word
  assign w_new = small_sig1(win[14]) + win[9] + small_sig0(win[1]) + win[0];

  assign ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1  = v[7] + big_sig1(v[4]) + ch + ROUND_K[cmd.round_idx] + win[0];
  assign t2  = big_sig0(v[0]) + maj;

  always_ff @(posedge clk) begin
    if (cmd.shift_in || cmd.round) begin
      for (int i = 0; i < BlkWords - 1; i++) win[i] <= win[i+1];
      win[BlkWords-1] <= cmd.shift_in ? in_word : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < HashWords; i++) v[i] <= cmd.init_hash ? INIT_HASH[i] : h[i];
    end else if (cmd.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HashWords; i++) h[i] <= INIT_HASH[i];
    end else if (cmd.start && cmd.init_hash) begin
      for (int i = 0; i < HashWords; i++) h[i] <= INIT_HASH[i];
    end else if (cmd.update) begin
      for (int i = 0; i < HashWords; i++) h[i] <= h[i] + v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word <= h[cmd.emit_idx];
      out_idx  <= cmd.emit_idx;
      out_last <= (cmd.emit_idx == 3'(HashWords - 1));
    end
  end

endmodule

// ----- rtl/core/sha256_block_compression.sv -----
// top level of the sha-256 block compression engine
// Takes a message that is already padded, as big-endian 32-bit words, sixteen
// transfers per 512-bit block; the first_block and final_block flags are only
// looked at on the sixteenth word of a block. A block with first_block set
// restarts from the standard initial hash value, otherwise it chains from the
// previous block. After a final block the eight digest words come out, H0
// first, with tlast on the eighth. A block costs 16 input transfers, then 64
// rounds (one round per cycle through the round adder chain, with the
// schedule expanded alongside in a 16-word shift window) and an update step
// that folds the result into the chaining value. Input is only taken while
// words of a block are being collected.

module sha256_block_compression
  import sha256c_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] message_word
  input  logic [1:0]  s_tuser,   // [0] first_block, [1] final_block
  // digest stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] digest_index
  output logic        m_tlast    // digest_last
);

  sha256c_cmd_t  cmd;
  sha256c_stat_t stat;

  // sequencing of load, rounds, update and digest output
  sha256c_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_first (s_tuser[0]),
    .in_final (s_tuser[1]),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hashing state and the registered output stage
  sha256c_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (m_tdata),
    .out_idx   (m_tuser),
    .out_last  (m_tlast)
  );

endmodule
